// File: src/lru_pkg.sv
// Shared types and constants for the LRU page replacement block.
// Depends on nothing; every other file imports it.
package lru_pkg;

    // Default sizes for the top-level parameters.
    localparam int LRU_MAX_FRAMES  = 8;
    localparam int LRU_NUM_PAGES   = 16;
    localparam int LRU_COUNT_WIDTH = 16;

    // Fixed widths of the transaction fields and the configuration register.
    localparam int LRU_PAGE_W  = 4;
    localparam int LRU_FRAME_W = 3;
    localparam int LRU_CNT_W   = 16;
    localparam int LRU_CFG_W   = 4;

    // Frame count after reset.
    localparam logic [LRU_CFG_W-1:0] LRU_CFG_RESET = 4'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

// File: src/lru_if.sv
// Valid/ready channel interfaces for page references and replacement results.
// Depends on lru_pkg for the field widths.
interface lru_req_if;
    import lru_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LRU_PAGE_W-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface lru_rsp_if;
    import lru_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic                   evicted;
    logic [LRU_FRAME_W-1:0] frame;
    logic [LRU_PAGE_W-1:0]  victim_page;
    logic [LRU_CNT_W-1:0]   page_refs;
    logic [LRU_CNT_W-1:0]   hit_count;
    logic [LRU_CNT_W-1:0]   miss_count;
    logic [LRU_CNT_W-1:0]   evict_count;

    modport source (
        output valid, output hit, output evicted, output frame, output victim_page,
        output page_refs, output hit_count, output miss_count, output evict_count,
        input ready
    );
    modport sink (
        input valid, input hit, input evicted, input frame, input victim_page,
        input page_refs, input hit_count, input miss_count, input evict_count,
        output ready
    );
endinterface

// File: src/lru_hist.sv
// Per-page reference histogram: one-port-read, one-port-write memory with
// per-entry valid bits so that reset clears it at once. Depends on lru_pkg.
module lru_hist #(
    parameter int NUM_PAGES   = lru_pkg::LRU_NUM_PAGES,
    parameter int COUNT_WIDTH = lru_pkg::LRU_COUNT_WIDTH,
    parameter int HW          = $clog2(NUM_PAGES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [HW-1:0]          i_rd_idx,
    output logic [COUNT_WIDTH-1:0] o_rd_data,
    input  logic                   i_wr_en,
    input  logic [HW-1:0]          i_wr_idx,
    input  logic [COUNT_WIDTH-1:0] i_wr_data
);
    import lru_pkg::*;

    logic [COUNT_WIDTH-1:0] r_mem [NUM_PAGES];
    logic [NUM_PAGES-1:0]   r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_valid;

    // Valid bits: cleared by reset, set on the first write of an entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    // Storage array with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx];
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    // An entry never written since reset reads as zero.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: src/lru_page_replacement.sv
// LRU page replacement over a configurable number of frames; uses lru_pkg, lru_if, lru_hist.
// Steps: accept, scan, update. The scan compares the frames in use (N of them) one at a time,
// and a hit stops it early; the update then reorders the list and loads the result register.
// A new reference is accepted only once the update is done and the block is idle again; the update
// waits while the previous result is still held in the output register.
// Reset (synchronous, active low): frames empty, order 0 upward, counts zero, N = 4.
module lru_page_replacement #(
    parameter int MAX_FRAMES  = lru_pkg::LRU_MAX_FRAMES,
    parameter int NUM_PAGES   = lru_pkg::LRU_NUM_PAGES,
    parameter int COUNT_WIDTH = lru_pkg::LRU_COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lru_pkg::LRU_CFG_W-1:0]   i_cfg_wdata,
    lru_req_if.sink                         i_req,
    lru_rsp_if.source                       o_rsp
);
    import lru_pkg::*;

    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int HW = $clog2(NUM_PAGES);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Sequencer and scan state.
    t_state                 r_state, n_state;
    logic [CW-1:0]          r_nfr;
    logic [FW-1:0]          r_pos;
    logic [FW-1:0]          r_tpos;
    logic                   r_hit;
    logic [LRU_PAGE_W-1:0]  r_page;

    // Recency list, oldest first: each position carries its frame, valid and page.
    logic [FW-1:0]          r_ord_frame [MAX_FRAMES];
    logic                   r_ord_valid [MAX_FRAMES];
    logic [LRU_PAGE_W-1:0]  r_ord_page  [MAX_FRAMES];
    logic [FW-1:0]          n_ord_frame [MAX_FRAMES];
    logic                   n_ord_valid [MAX_FRAMES];
    logic [LRU_PAGE_W-1:0]  n_ord_page  [MAX_FRAMES];

    // Running totals.
    logic [COUNT_WIDTH-1:0] r_hits, r_misses, r_evicts;
    logic [COUNT_WIDTH-1:0] n_hits, n_misses, n_evicts;

    // Result register.
    logic                   r_rsp_valid;
    logic                   r_rsp_hit;
    logic                   r_rsp_evicted;
    logic [LRU_FRAME_W-1:0] r_rsp_frame;
    logic [LRU_PAGE_W-1:0]  r_rsp_victim;
    logic [LRU_CNT_W-1:0]   r_rsp_refs;

    // Control and datapath signals.
    logic                   w_accept;
    logic                   w_match;
    logic                   w_last;
    logic                   w_upd_go;
    logic                   w_in_range;
    logic [HW-1:0]          w_hist_idx;
    logic [COUNT_WIDTH-1:0] w_hist_q;
    logic [COUNT_WIDTH-1:0] n_refs;
    logic [FW-1:0]          w_frame;
    logic                   w_evict;
    logic [CW-1:0]          w_cfg_nfr;

    // Clamp a written frame count into 1..MAX_FRAMES.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_nfr = CW'(1);
        end else if (int'(i_cfg_wdata) > MAX_FRAMES) begin
            w_cfg_nfr = CW'(MAX_FRAMES);
        end else begin
            w_cfg_nfr = CW'(i_cfg_wdata);
        end
    end

    // Handshake and scan decisions.
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        w_accept    = i_req.valid && (r_state == ST_IDLE);
        w_match     = r_ord_valid[r_pos] && (r_ord_page[r_pos] == r_page);
        w_last      = (CW'(r_pos) == r_nfr - CW'(1));
        w_upd_go    = (r_state == ST_UPDATE) && (!r_rsp_valid || o_rsp.ready);
        w_in_range  = int'(r_page) < NUM_PAGES;
        w_hist_idx  = HW'(r_page);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_match || w_last) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_upd_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan position walks one recency slot per cycle and records the outcome.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_tpos <= '0;
            r_hit  <= 1'b0;
        end else if (w_accept) begin
            r_pos <= '0;
            r_hit <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            if (w_match) begin
                r_hit  <= 1'b1;
                r_tpos <= r_pos;
            end else if (w_last) begin
                r_hit  <= 1'b0;
                r_tpos <= '0;
            end else begin
                r_pos <= r_pos + FW'(1);
            end
        end
    end

    // Reference page is held for the whole transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= i_req.page;
        end
    end

    // Histogram memory: read on accept, write back in the update cycle.
    lru_hist #(
        .NUM_PAGES   (NUM_PAGES),
        .COUNT_WIDTH (COUNT_WIDTH),
        .HW          (HW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_idx  (HW'(i_req.page)),
        .o_rd_data (w_hist_q),
        .i_wr_en   (w_upd_go && w_in_range),
        .i_wr_idx  (w_hist_idx),
        .i_wr_data (n_refs)
    );

    // Update datapath: move the chosen slot to the newest end and bump the counts.
    always_comb begin
        n_refs    = (w_hist_q == CNT_MAX) ? w_hist_q : w_hist_q + COUNT_WIDTH'(1);
        w_frame   = r_ord_frame[r_tpos];
        w_evict   = !r_hit && r_ord_valid[r_tpos];
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_evicts  = r_evicts;
        if (r_hit) begin
            if (r_hits != CNT_MAX) n_hits = r_hits + COUNT_WIDTH'(1);
        end else begin
            if (r_misses != CNT_MAX) n_misses = r_misses + COUNT_WIDTH'(1);
            if (w_evict && (r_evicts != CNT_MAX)) n_evicts = r_evicts + COUNT_WIDTH'(1);
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            n_ord_frame[i] = r_ord_frame[i];
            n_ord_valid[i] = r_ord_valid[i];
            n_ord_page[i]  = r_ord_page[i];
        end
        for (int i = 0; i < MAX_FRAMES - 1; i++) begin
            if ((i >= int'(r_tpos)) && (i < int'(r_nfr) - 1)) begin
                n_ord_frame[i] = r_ord_frame[i + 1];
                n_ord_valid[i] = r_ord_valid[i + 1];
                n_ord_page[i]  = r_ord_page[i + 1];
            end
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (i == int'(r_nfr) - 1) begin
                n_ord_frame[i] = w_frame;
                n_ord_valid[i] = 1'b1;
                n_ord_page[i]  = r_page;
            end
        end
    end

    // Frame count and recency list; a configuration write empties all frames.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfr <= (int'(LRU_CFG_RESET) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(LRU_CFG_RESET);
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_ord_frame[i] <= FW'(i);
                r_ord_valid[i] <= 1'b0;
            end
        end else if (i_cfg_we) begin
            r_nfr <= w_cfg_nfr;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_ord_frame[i] <= FW'(i);
                r_ord_valid[i] <= 1'b0;
            end
        end else if (w_upd_go) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_ord_frame[i] <= n_ord_frame[i];
                r_ord_valid[i] <= n_ord_valid[i];
            end
        end
    end

    // Pages travel with their slots; only read where the slot is valid.
    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_ord_page[i] <= n_ord_page[i];
            end
        end
    end

    // Running totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (w_upd_go) begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_evicts <= n_evicts;
        end
    end

    // Result register: loaded in the update cycle, released by the output transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_upd_go) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            r_rsp_hit     <= r_hit;
            r_rsp_evicted <= w_evict;
            r_rsp_frame   <= LRU_FRAME_W'(w_frame);
            r_rsp_victim  <= w_evict ? r_ord_page[r_tpos] : '0;
            r_rsp_refs    <= w_in_range ? LRU_CNT_W'(n_refs) : '0;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.hit         = r_rsp_hit;
    assign o_rsp.evicted     = r_rsp_evicted;
    assign o_rsp.frame       = r_rsp_frame;
    assign o_rsp.victim_page = r_rsp_victim;
    assign o_rsp.page_refs   = r_rsp_refs;
    assign o_rsp.hit_count   = LRU_CNT_W'(r_hits);
    assign o_rsp.miss_count  = LRU_CNT_W'(r_misses);
    assign o_rsp.evict_count = LRU_CNT_W'(r_evicts);

    // An accepted reference always starts a scan on the next cycle.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN))
        else $error("accepted reference did not start a scan");

    // The scan never looks past the frames in use.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CW'(r_pos) < r_nfr))
        else $error("scan position beyond frames in use");

    // The frame count stays within its legal range.
    a_nfr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfr != '0) && (int'(r_nfr) <= MAX_FRAMES))
        else $error("frame count out of range");

    // A hit never evicts a page.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.hit && o_rsp.evicted))
        else $error("result reports both hit and eviction");

endmodule

// File: tb/lru_page_replacement_tb.sv
// Self-checking testbench for the LRU page replacement block.
// Depends on lru_pkg, the lru_req_if/lru_rsp_if channels and lru_page_replacement.
module lru_page_replacement_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lru_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int IDLE_PERCENT   = 27;
    localparam int PHASE_ITEMS    = 120;

    // One replacement result as the block reports it.
    typedef struct packed {
        logic                  hit;
        logic                  evicted;
        logic [LRU_FRAME_W-1:0] frame;
        logic [LRU_PAGE_W-1:0]  victim_page;
        logic [LRU_CNT_W-1:0]   page_refs;
        logic [LRU_CNT_W-1:0]   hit_count;
        logic [LRU_CNT_W-1:0]   miss_count;
        logic [LRU_CNT_W-1:0]   evict_count;
    } t_lru_result;

    typedef enum logic {
        ROW_REF,
        ROW_CFG
    } t_row_kind;

    // One line of the directed sequence: a page reference or a frame-count write.
    typedef struct packed {
        t_row_kind             kind;
        logic [LRU_PAGE_W-1:0] value;
        logic                  typed;
        t_lru_result           result;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LRU_CFG_W-1:0] i_cfg_wdata;

    lru_req_if req_ch ();
    lru_rsp_if rsp_ch ();

    lru_page_replacement uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // Shadow state of the replacement logic.
    logic [LRU_PAGE_W-1:0]  shadow_page [LRU_MAX_FRAMES];
    bit                     shadow_valid [LRU_MAX_FRAMES];
    logic [LRU_FRAME_W-1:0] shadow_order [LRU_MAX_FRAMES];
    logic [LRU_CNT_W-1:0]   shadow_hits;
    logic [LRU_CNT_W-1:0]   shadow_misses;
    logic [LRU_CNT_W-1:0]   shadow_evicts;
    logic [LRU_CNT_W-1:0]   shadow_hist [LRU_NUM_PAGES];
    int                     active_frames;

    t_lru_result   pending_results[$];
    t_directed_row directed_rows[$];
    t_lru_result   want;

    bit idle_enable;
    int mismatches;
    int refs_sent;
    int cfg_writes;
    int seen_hits;
    int seen_misses;
    int seen_evicts;
    int quiet_cycles = 0;

    // Clock.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Saturating increment of a counter.
    function automatic logic [LRU_CNT_W-1:0] sat_inc(input logic [LRU_CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Empty every frame and restore the order 0 upward.
    function automatic void empty_frames();
        for (int i = 0; i < LRU_MAX_FRAMES; i++) begin
            shadow_page[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_order[i] = i[LRU_FRAME_W-1:0];
        end
    endfunction

    // Apply a frame-count write, with out-of-range values clamped.
    function automatic void set_frames(input logic [LRU_CFG_W-1:0] val);
        if (val == 0) begin
            active_frames = 1;
        end else if (int'(val) > LRU_MAX_FRAMES) begin
            active_frames = LRU_MAX_FRAMES;
        end else begin
            active_frames = int'(val);
        end
        empty_frames();
    endfunction

    // Move the frame at position pos of the order to the newest end.
    function automatic void promote(input int pos);
        logic [LRU_FRAME_W-1:0] f;
        f = shadow_order[pos];
        for (int i = pos; i + 1 < active_frames; i++) begin
            shadow_order[i] = shadow_order[i + 1];
        end
        shadow_order[active_frames - 1] = f;
    endfunction

    // Reference one page: update the shadow state and return the result it gives.
    function automatic t_lru_result lru_access(input logic [LRU_PAGE_W-1:0] pg);
        t_lru_result            r;
        logic [LRU_FRAME_W-1:0] f;
        r = '0;
        shadow_hist[pg] = sat_inc(shadow_hist[pg]);
        r.page_refs = shadow_hist[pg];
        for (int pos = 0; pos < active_frames; pos++) begin
            f = shadow_order[pos];
            if (!r.hit && shadow_valid[f] && shadow_page[f] == pg) begin
                r.hit   = 1'b1;
                r.frame = f;
                promote(pos);
            end
        end
        if (r.hit) begin
            shadow_hits = sat_inc(shadow_hits);
        end else begin
            f = shadow_order[0];
            r.frame = f;
            if (shadow_valid[f]) begin
                r.evicted     = 1'b1;
                r.victim_page = shadow_page[f];
                shadow_evicts = sat_inc(shadow_evicts);
            end
            shadow_page[f]  = pg;
            shadow_valid[f] = 1'b1;
            promote(0);
            shadow_misses = sat_inc(shadow_misses);
        end
        r.hit_count   = shadow_hits;
        r.miss_count  = shadow_misses;
        r.evict_count = shadow_evicts;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Append one line to the directed sequence.
    function automatic void add_row(input t_directed_row row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Send one reference; at acceptance queue its expected result.
    task automatic send_ref(input logic [LRU_PAGE_W-1:0] pg, input bit typed,
                            input t_lru_result typed_result);
        t_lru_result r;
        while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.page  <= pg;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        r = lru_access(pg);
        pending_results.insert(pending_results.size(), typed ? typed_result : r);
        refs_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender off until every expected result has arrived.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (active_frames + 4) @(negedge i_clk);
    endtask

    // Frame-count write, only once the block has gone idle.
    task automatic write_frames(input logic [LRU_CFG_W-1:0] val);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        set_frames(val);
        cfg_writes++;
    endtask

    // Random reference biased toward a small working set, so hits and evictions both occur.
    function automatic logic [LRU_PAGE_W-1:0] pick_page(inout logic [LRU_PAGE_W-1:0] base);
        logic [LRU_PAGE_W-1:0] span;
        if ($urandom_range(99) < 5) base = LRU_PAGE_W'($urandom_range(LRU_NUM_PAGES - 1));
        span = LRU_PAGE_W'($urandom_range(active_frames));
        if ($urandom_range(99) < 70) return base + span;
        return LRU_PAGE_W'($urandom_range(LRU_NUM_PAGES - 1));
    endfunction

    // Directed sequence: fill, hit, evict, and every clamp of the frame count.
    task automatic load_directed();
        add_row('{ROW_REF, 4'd0, 1'b1,
            '{1'b0, 1'b0, 3'd0, 4'd0, 16'd1, 16'd0, 16'd1, 16'd0}});
        add_row('{ROW_REF, 4'd0, 1'b1,
            '{1'b1, 1'b0, 3'd0, 4'd0, 16'd2, 16'd1, 16'd1, 16'd0}});
        add_row('{ROW_REF, 4'd15, 1'b1,
            '{1'b0, 1'b0, 3'd1, 4'd0, 16'd1, 16'd1, 16'd2, 16'd0}});
        add_row('{ROW_REF, 4'd5, 1'b0, '0});
        add_row('{ROW_REF, 4'd10, 1'b0, '0});
        add_row('{ROW_REF, 4'd3, 1'b0, '0});
        add_row('{ROW_REF, 4'd15, 1'b0, '0});
        add_row('{ROW_REF, 4'd0, 1'b0, '0});
        add_row('{ROW_CFG, 4'd0, 1'b0, '0});
        add_row('{ROW_REF, 4'd9, 1'b0, '0});
        add_row('{ROW_REF, 4'd9, 1'b0, '0});
        add_row('{ROW_REF, 4'd6, 1'b0, '0});
        add_row('{ROW_CFG, 4'd15, 1'b0, '0});
        add_row('{ROW_REF, 4'd1, 1'b0, '0});
        add_row('{ROW_REF, 4'd2, 1'b0, '0});
        add_row('{ROW_REF, 4'd4, 1'b0, '0});
        add_row('{ROW_REF, 4'd8, 1'b0, '0});
        add_row('{ROW_REF, 4'd15, 1'b0, '0});
        add_row('{ROW_REF, 4'd7, 1'b0, '0});
        add_row('{ROW_REF, 4'd11, 1'b0, '0});
        add_row('{ROW_REF, 4'd12, 1'b0, '0});
        add_row('{ROW_REF, 4'd1, 1'b0, '0});
        add_row('{ROW_REF, 4'd13, 1'b0, '0});
        add_row('{ROW_CFG, 4'd1, 1'b0, '0});
        add_row('{ROW_REF, 4'd14, 1'b0, '0});
        add_row('{ROW_REF, 4'd14, 1'b0, '0});
        add_row('{ROW_CFG, 4'd8, 1'b0, '0});
        add_row('{ROW_REF, 4'd14, 1'b0, '0});
    endtask

    // Result side: random back-pressure while idling is enabled.
    always @(negedge i_clk) begin
        rsp_ch.ready <= !idle_enable || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no reference pending");
                mismatches++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("hit", want.hit, rsp_ch.hit);
                check_field("evicted", want.evicted, rsp_ch.evicted);
                check_field("frame", want.frame, rsp_ch.frame);
                check_field("victim_page", want.victim_page, rsp_ch.victim_page);
                check_field("page_refs", want.page_refs, rsp_ch.page_refs);
                check_field("hit_count", want.hit_count, rsp_ch.hit_count);
                check_field("miss_count", want.miss_count, rsp_ch.miss_count);
                check_field("evict_count", want.evict_count, rsp_ch.evict_count);
                if (rsp_ch.hit) seen_hits++;
                else seen_misses++;
                if (rsp_ch.evicted) seen_evicts++;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        logic [LRU_PAGE_W-1:0]  ws_base;
        logic [LRU_CFG_W-1:0]   phase_cfg;
        t_directed_row          row;
        logic [LRU_CFG_W-1:0]   extremes [4];

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_ch.valid = 1'b0;
        req_ch.page  = '0;
        idle_enable  = 1'b1;
        mismatches   = 0;
        refs_sent    = 0;
        cfg_writes   = 0;
        seen_hits    = 0;
        seen_misses  = 0;
        seen_evicts  = 0;
        ws_base      = '0;
        extremes     = '{4'd1, 4'd8, 4'd0, 4'd15};

        // Shadow state matches the block after reset.
        set_frames(LRU_CFG_RESET);
        shadow_hits   = '0;
        shadow_misses = '0;
        shadow_evicts = '0;
        for (int i = 0; i < LRU_NUM_PAGES; i++) shadow_hist[i] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part.
        load_directed();
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG) begin
                write_frames(row.value);
            end else begin
                send_ref(row.value, row.typed, row.result);
            end
        end

        // Random part: one frame-count setting per phase, extremes first.
        for (int phase = 0; phase < 6; phase++) begin
            phase_cfg = (phase < 4) ? extremes[phase] : LRU_CFG_W'($urandom_range(15));
            write_frames(phase_cfg);
            idle_enable = (phase != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((phase == 3 && n == 40) || $urandom_range(199) == 0) begin
                    drain_results();
                end
                send_ref(pick_page(ws_base), 1'b0, '0);
            end
        end

        drain_results();
        repeat (LRU_MAX_FRAMES + 4) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatches++;
        end

        $display("Covered %0d references and %0d frame-count writes (clamped values included).",
                 refs_sent, cfg_writes);
        $display("Results: %0d hits, %0d misses, %0d evictions, with and without back-pressure.",
                 seen_hits, seen_misses, seen_evicts);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
